// ----- src/clustered_light_binning_assert.svh -----
// Assertion macros shared by the checker of the clustered light binning block.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef CLUSTERED_LIGHT_BINNING_ASSERT_SVH
`define CLUSTERED_LIGHT_BINNING_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/clb_pkg.sv -----
// Package of the clustered light binning block: grid sizes, widths, codes
// and index helpers. Used by the divider and the top module of the block; depends on nothing.
`default_nettype none

package clb_pkg;

  // Grid and list sizes (powers of two: cluster addresses are concatenated)
  localparam int SLICES_X           = 16;
  localparam int SLICES_Y           = 8;
  localparam int SLICES_Z           = 32;
  localparam int LIGHTS_PER_CLUSTER = 16;
  localparam int LIGHT_INDEX_BITS   = 8;

  localparam int XW      = $clog2(SLICES_X);
  localparam int YW      = $clog2(SLICES_Y);
  localparam int ZW      = $clog2(SLICES_Z);
  localparam int NCELLS  = SLICES_X * SLICES_Y * SLICES_Z;
  localparam int CELL_W  = $clog2(NCELLS);
  localparam int SLOT_W  = $clog2(LIGHTS_PER_CLUSTER);
  localparam int LADDR_W = CELL_W + SLOT_W;
  localparam int CNT_W   = $clog2(LIGHTS_PER_CLUSTER + 1);

  // Datapath widths
  localparam int NUM_W = 54;   // signed numerator of a bin quotient
  localparam int DEN_W = 49;   // positive divisor
  localparam int QUO_W = 55;   // signed floored quotient
  localparam int TOT_W = 13;   // per-light cluster tallies
  localparam int H_W   = 48;   // frustum half extents

  localparam logic [H_W-1:0] W_MAX = 48'h8000_0000_0000;

  // Register reset values
  localparam logic [30:0] TAN_RESET    = 31'd27146;
  localparam logic [30:0] ASPECT_RESET = 31'd116508;
  localparam logic [30:0] STRIDE_RESET = 31'd2048000;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_TAN    = 2'd0;
  localparam logic [1:0] REG_ASPECT = 2'd1;
  localparam logic [1:0] REG_STRIDE = 2'd2;

  // Commands
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_BIN   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // True when a floored quotient lies below the grid.
  function automatic logic below_grid(input logic [QUO_W-1:0] q);
    return q[QUO_W-1];
  endfunction

  // True when a floored quotient lies at or beyond n.
  function automatic logic above_grid(input logic [QUO_W-1:0] q, input int n);
    return !q[QUO_W-1] && (q >= QUO_W'(n));
  endfunction

  // Clamp a quotient into [0, n-1], returned on eight bits.
  function automatic logic [7:0] clamp_idx(input logic [QUO_W-1:0] q, input int n);
    logic [7:0] res;
    if (below_grid(q)) begin
      res = '0;
    end else if (above_grid(q, n)) begin
      res = 8'(n - 1);
    end else begin
      res = q[7:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- src/clb_divider.sv -----
// Iterative floored divider of the clustered light binning block, one quotient
// bit per cycle. Depends on clb_pkg for its widths.
`default_nettype none

module clb_divider
  import clb_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic        [DEN_W-1:0] den,
  output logic                         done,
  output logic             [QUO_W-1:0] quo
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_r;
  logic              fin_r;
  logic [STEP_W-1:0] step_r;
  logic [NUM_W-1:0]  mag_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic              neg_r;
  logic              done_r;
  logic [QUO_W-1:0]  quo_r;

  logic [DEN_W:0]    shifted;
  logic              fits;
  logic [DEN_W:0]    diff;
  logic [QUO_W-1:0]  mag_ext;

  // One restoring step: shift in the next numerator bit and try the divisor.
  always_comb begin
    shifted = {rem_r, mag_r[NUM_W-1]};
    diff    = shifted - {1'b0, den_r};
    fits    = shifted >= {1'b0, den_r};
    mag_ext = QUO_W'(mag_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      if (start) begin
        done_r <= 1'b0;
        busy_r <= 1'b1;
        step_r <= STEP_W'(NUM_W);
        neg_r  <= num[NUM_W-1];
        mag_r  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        done_r <= 1'b0;
        mag_r  <= {mag_r[NUM_W-2:0], fits};
        rem_r  <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        // Floor toward minus infinity for a negative numerator.
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        if (neg_r) begin
          quo_r <= -mag_ext - QUO_W'(rem_r != '0);
        end else begin
          quo_r <= mag_ext;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

// ----- src/clustered_light_binning.sv -----
// Clustered light binning: bins spherical lights into a grid of frustum clusters.
// A bin first does its box arithmetic (six floored quotients on the shared
// bit-serial divider), then a count-memory read-modify-write for each cluster in
// the clamped box. A read passes through a request and a data state; a clear
// sweeps the count memory at one entry a cycle. After reset the same sweep runs
// and no item is accepted until it ends. One item is worked on at a time.
`default_nettype none

module clustered_light_binning
  import clb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Input: light_index, pos_x, pos_y, pos_depth, radius, cell_x, cell_y, cell_z,
  // slot from bit 0 up, one zero bit on top.
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [151:0] in_tdata,
  // command
  input  wire logic [1:0]   in_tuser,
  // Result: culled, clusters_written, clusters_full, cell_count, slot_light.
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [39:0]       out_tdata,
  // Configuration writes
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [30:0]  cfg_data
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_DIV_GO, ST_DIV_WAIT,
    ST_CHECK, ST_WALK_RD, ST_WALK_WR, ST_RD_REQ, ST_RD_DATA, ST_FINISH
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [30:0] tan_r, aspect_r, stride_r;

  // Captured item
  logic [7:0]         li_r;
  logic signed [31:0] px_r, py_r, pd_r;
  logic [30:0]        rad_r;
  logic [XW-1:0]      cx_r;
  logic [YW-1:0]      cy_r;
  logic [ZW-1:0]      cz_r;
  logic [SLOT_W-1:0]  slot_r;

  // Frustum arithmetic
  logic [62:0]      prod_r, pa_r;
  logic [46:0]      pb_r;
  logic [H_W-1:0]   h_r, w_r;
  logic [2:0]       k_r;
  logic [QUO_W-1:0] q_r [6];

  // Walk
  logic [XW-1:0] x_r, xs_r, xe_r;
  logic [YW-1:0] y_r, ys_r, ye_r;
  logic [ZW-1:0] z_r, zs_r, ze_r;
  logic [TOT_W-1:0] written_r, full_r;
  logic [CELL_W-1:0] clr_addr_r;
  logic clr_cmd_r;

  // Result
  logic             res_culled_r;
  logic [CNT_W-1:0] res_count_r;
  logic [7:0]       res_slot_r;
  logic             out_tvalid_r;
  logic [39:0]      out_tdata_r;

  // Memories
  logic [CNT_W-1:0]            count_mem [NCELLS];
  logic [LIGHT_INDEX_BITS-1:0] light_mem [NCELLS * LIGHTS_PER_CLUSTER];
  logic                        cnt_we;
  logic [CELL_W-1:0]           cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]            cnt_wdata, cnt_q;
  logic                        lit_we;
  logic [LADDR_W-1:0]          lit_waddr, lit_raddr;
  logic [LIGHT_INDEX_BITS-1:0] lit_q;

  // Divider
  logic                    div_start, div_done;
  logic signed [NUM_W-1:0] div_num;
  logic [DEN_W-1:0]        div_den;
  logic [QUO_W-1:0]        div_quo;

  logic [31:0]             abs_depth;
  logic signed [NUM_W-1:0] pd_e, px_e, py_e, r_e, h_e, w_e;
  logic [CELL_W-1:0]       walk_id, read_id;
  logic [62:0]             w_sum;
  logic                    cull_box;
  logic [QUO_W-1:0]        q_adj;

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Operand preparation
  always_comb begin
    abs_depth = pd_r[31] ? (~pd_r + 32'd1) : pd_r;
    pd_e = NUM_W'(pd_r);
    px_e = NUM_W'(px_r);
    py_e = NUM_W'(py_r);
    r_e  = $signed({{(NUM_W-31){1'b0}}, rad_r});
    h_e  = $signed({{(NUM_W-H_W){1'b0}}, h_r});
    w_e  = $signed({{(NUM_W-H_W){1'b0}}, w_r});
    w_sum = pa_r + (63'(pb_r) >> 16);
    walk_id = {z_r, y_r, x_r};
    read_id = {cz_r, cy_r, cx_r};
  end

  // Numerator and divisor of the k-th box bound: z, then y, then x, start before end.
  always_comb begin
    case (k_r)
      3'd0: div_num = pd_e - r_e;
      3'd1: div_num = pd_e + r_e;
      3'd2: div_num = NUM_W'(((py_e - r_e) * 2 + h_e) * SLICES_Y);
      3'd3: div_num = NUM_W'(((py_e + r_e) * 2 + h_e) * SLICES_Y);
      3'd4: div_num = NUM_W'(((px_e - r_e) * 2 + w_e) * SLICES_X);
      default: div_num = NUM_W'(((px_e + r_e) * 2 + w_e) * SLICES_X);
    endcase
    if (k_r < 3'd2) begin
      div_den = DEN_W'(stride_r);
    end else if (k_r < 3'd4) begin
      div_den = {h_r, 1'b0};
    end else begin
      div_den = {w_r, 1'b0};
    end
    div_start = (state_r == ST_DIV_GO);
  end

  // The x range is widened by one cell on each side.
  always_comb begin
    case (k_r)
      3'd4:    q_adj = div_quo - QUO_W'(1);
      3'd5:    q_adj = div_quo + QUO_W'(1);
      default: q_adj = div_quo;
    endcase
  end

  // A box that misses the grid on any axis is culled.
  always_comb begin
    cull_box = (below_grid(q_r[0]) && below_grid(q_r[1]))
            || (above_grid(q_r[0], SLICES_Z) && above_grid(q_r[1], SLICES_Z))
            || (below_grid(q_r[2]) && below_grid(q_r[3]))
            || (above_grid(q_r[2], SLICES_Y) && above_grid(q_r[3], SLICES_Y))
            || (below_grid(q_r[4]) && below_grid(q_r[5]))
            || (above_grid(q_r[4], SLICES_X) && above_grid(q_r[5], SLICES_X));
  end

  // Memory access control
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = walk_id;
    cnt_wdata = cnt_q + CNT_W'(1);
    lit_we    = 1'b0;
    lit_waddr = {walk_id, cnt_q[SLOT_W-1:0]};
    cnt_raddr = (state_r == ST_RD_REQ) ? read_id : walk_id;
    lit_raddr = {read_id, slot_r};
    case (state_r)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr_r;
        cnt_wdata = '0;
      end
      ST_WALK_WR: begin
        cnt_we = (cnt_q < CNT_W'(LIGHTS_PER_CLUSTER));
        lit_we = cnt_we;
      end
      default: ;
    endcase
  end

  // Cluster count memory
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q <= count_mem[cnt_raddr];
  end

  // Cluster light list memory
  always_ff @(posedge clk) begin
    if (lit_we) begin
      light_mem[lit_waddr] <= li_r[LIGHT_INDEX_BITS-1:0];
    end
    lit_q <= light_mem[lit_raddr];
  end

  clb_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Configuration registers: a written zero acts as one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tan_r    <= TAN_RESET;
      aspect_r <= ASPECT_RESET;
      stride_r <= STRIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TAN:    tan_r    <= (cfg_data == '0) ? 31'd1 : cfg_data;
        REG_ASPECT: aspect_r <= (cfg_data == '0) ? 31'd1 : cfg_data;
        REG_STRIDE: stride_r <= (cfg_data == '0) ? 31'd1 : cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer with the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      clr_cmd_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // A taken result is dropped, unless a new one is loaded in the same cycle.
      if (out_tvalid_r && out_tready && state_r != ST_FINISH) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == CELL_W'(NCELLS - 1)) begin
            state_r <= clr_cmd_r ? ST_FINISH : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_tvalid) begin
            li_r         <= in_tdata[7:0];
            px_r         <= in_tdata[39:8];
            py_r         <= in_tdata[71:40];
            pd_r         <= in_tdata[103:72];
            rad_r        <= in_tdata[134:104];
            cx_r         <= in_tdata[138:135];
            cy_r         <= in_tdata[141:139];
            cz_r         <= in_tdata[146:142];
            slot_r       <= in_tdata[150:147];
            res_culled_r <= 1'b0;
            written_r    <= '0;
            full_r       <= '0;
            res_count_r  <= '0;
            res_slot_r   <= '0;
            k_r          <= '0;
            clr_addr_r   <= '0;
            clr_cmd_r    <= 1'b1;
            case (in_tuser)
              CMD_CLEAR: state_r <= ST_CLEAR;
              CMD_BIN:   state_r <= ST_MUL1;
              CMD_READ:  state_r <= ST_RD_REQ;
              default:   state_r <= ST_FINISH;
            endcase
          end
        end
        ST_MUL1: begin
          prod_r <= 63'(tan_r) * 63'(abs_depth);
          if (pd_r == '0) begin
            res_culled_r <= 1'b1;
            state_r      <= ST_FINISH;
          end else begin
            state_r <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          h_r     <= (prod_r[62:15] == '0) ? H_W'(1) : prod_r[62:15];
          state_r <= ST_MUL3;
        end
        ST_MUL3: begin
          pa_r    <= 63'(aspect_r) * 63'(h_r[47:16]);
          pb_r    <= 47'(aspect_r) * 47'(h_r[15:0]);
          state_r <= ST_MUL4;
        end
        ST_MUL4: begin
          if (w_sum == '0) begin
            w_r <= H_W'(1);
          end else if (w_sum > 63'(W_MAX)) begin
            w_r <= W_MAX;
          end else begin
            w_r <= w_sum[H_W-1:0];
          end
          state_r <= ST_DIV_GO;
        end
        ST_DIV_GO: begin
          state_r <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            q_r[k_r] <= q_adj;
            k_r      <= k_r + 1'b1;
            state_r  <= (k_r == 3'd5) ? ST_CHECK : ST_DIV_GO;
          end
        end
        ST_CHECK: begin
          zs_r <= ZW'(clamp_idx(q_r[0], SLICES_Z));
          ze_r <= ZW'(clamp_idx(q_r[1], SLICES_Z));
          ys_r <= YW'(clamp_idx(q_r[2], SLICES_Y));
          ye_r <= YW'(clamp_idx(q_r[3], SLICES_Y));
          xs_r <= XW'(clamp_idx(q_r[4], SLICES_X));
          xe_r <= XW'(clamp_idx(q_r[5], SLICES_X));
          z_r  <= ZW'(clamp_idx(q_r[0], SLICES_Z));
          y_r  <= YW'(clamp_idx(q_r[2], SLICES_Y));
          x_r  <= XW'(clamp_idx(q_r[4], SLICES_X));
          if (cull_box) begin
            res_culled_r <= 1'b1;
            state_r      <= ST_FINISH;
          end else begin
            state_r <= ST_WALK_RD;
          end
        end
        ST_WALK_RD: begin
          state_r <= ST_WALK_WR;
        end
        ST_WALK_WR: begin
          // Tally this cluster and step x, then y, then z.
          if (cnt_q < CNT_W'(LIGHTS_PER_CLUSTER)) begin
            written_r <= written_r + 1'b1;
          end else begin
            full_r <= full_r + 1'b1;
          end
          state_r <= ST_WALK_RD;
          if (x_r == xe_r) begin
            x_r <= xs_r;
            if (y_r == ye_r) begin
              y_r <= ys_r;
              if (z_r == ze_r) begin
                state_r <= ST_FINISH;
              end else begin
                z_r <= z_r + 1'b1;
              end
            end else begin
              y_r <= y_r + 1'b1;
            end
          end else begin
            x_r <= x_r + 1'b1;
          end
        end
        ST_RD_REQ: begin
          state_r <= ST_RD_DATA;
        end
        ST_RD_DATA: begin
          // The read fields span the grid and the list exactly.
          res_count_r <= cnt_q;
          res_slot_r  <= 8'(lit_q);
          state_r     <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {res_slot_r, 5'(res_count_r), full_r, written_r,
                             res_culled_r};
            clr_cmd_r    <= 1'b0;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

// ----- src/clb_checker.sv -----
// Port-level checker of the clustered light binning block and its bind.
// Depends on clustered_light_binning_assert.svh for the assertion macros.
`default_nettype none

`include "clustered_light_binning_assert.svh"

module clb_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [39:0]  out_tdata
);

  logic       out_stall;
  logic       in_take;
  logic       out_culled;
  logic [4:0] out_count;

  assign out_stall  = out_tvalid && !out_tready;
  assign in_take    = in_tvalid && in_tready;
  assign out_culled = out_tvalid && out_tdata[0];
  assign out_count  = out_tdata[31:27];

  // A stalled result transaction keeps its data.
  `CLB_ASSERT_NEXT(a_hold, out_stall, out_tvalid && $stable(out_tdata), "result moved")

  // One item at a time: no acceptance in the cycle after a transaction.
  `CLB_ASSERT_NEXT(a_one_at_a_time, in_take, !in_tready, "input accepted while busy")

  // A culled light writes no cluster and finds none full.
  `CLB_ASSERT_SAME(a_culled_empty, out_culled, out_tdata[26:1] == 26'd0, "culled with tallies")

  // A cluster never holds more than its list length.
  `CLB_ASSERT_SAME(a_count_bound, out_tvalid, out_count <= 5'd16, "count beyond list length")

endmodule

bind clustered_light_binning clb_checker u_clb_checker (.*);

`default_nettype wire
